// ----- hw/rtl/gscc_pkg.sv -----
package gscc_pkg;

    localparam int COORD_W = 16;
    localparam int CFG_W   = 9;
    localparam int WIDE_W  = 18;   // holds any coordinate difference plus margin

    localparam int DEF_MAX_ROWS = 256;
    localparam int DEF_MAX_COLS = 256;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    // configuration register indexes
    localparam logic CFG_GRID_ROWS = 1'b0;
    localparam logic CFG_GRID_COLS = 1'b1;

    // operation codes
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_POINT   = 2'd1;
    localparam logic [1:0] OP_SEGMENT = 2'd2;

    typedef struct packed {
        logic [1:0]                operation;
        logic signed [COORD_W-1:0] row_a;
        logic signed [COORD_W-1:0] col_a;
        logic signed [COORD_W-1:0] row_b;
        logic signed [COORD_W-1:0] col_b;
        logic                      cell_blocked;
    } t_in_item;

    typedef struct packed {
        logic path_clear;
        logic in_bounds;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_START,
        ST_WALK_DN,
        ST_WALK_UP,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clear_en;
        logic capture;
        logic load_en;
        logic setup;
        logic walk_init;
        logic walk_step;
        logic issue;
        logic dir_up;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic       clear_last;
        logic [1:0] op;
        logic       in_bounds;
        logic       at_end;
        logic       out_busy;
    } t_status;

endpackage

// ----- hw/rtl/gscc_ctrl.sv -----
module gscc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  gscc_pkg::t_status i_status,
    output gscc_pkg::t_cmd    o_cmd
);
    import gscc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_status.clear_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                if (i_status.op == OP_POINT || i_status.op == OP_SEGMENT) begin
                    n_state = ST_START;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_START: begin
                n_state = i_status.in_bounds ? ST_WALK_DN : ST_DONE;
            end
            ST_WALK_DN: begin
                if (i_status.at_end) n_state = ST_WALK_UP;
            end
            ST_WALK_UP: begin
                if (i_status.at_end) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!i_status.out_busy) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_en = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_DECODE: begin
                o_cmd.load_en = (i_status.op == OP_LOAD);
                o_cmd.setup   = (i_status.op == OP_POINT || i_status.op == OP_SEGMENT);
            end
            ST_START: begin
                o_cmd.walk_init = i_status.in_bounds;
            end
            ST_WALK_DN: begin
                // walk from the second endpoint down, then restart there going up
                o_cmd.issue     = 1'b1;
                o_cmd.walk_init = i_status.at_end;
                o_cmd.walk_step = !i_status.at_end;
            end
            ST_WALK_UP: begin
                o_cmd.issue     = 1'b1;
                o_cmd.dir_up    = 1'b1;
                o_cmd.walk_step = !i_status.at_end;
            end
            ST_DRAIN: begin
            end
            ST_DONE: begin
                o_cmd.out_load = !i_status.out_busy;
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- hw/rtl/gscc_dp.sv -----
module gscc_dp #(
    parameter int MAX_ROWS = gscc_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gscc_pkg::DEF_MAX_COLS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_index,
    input  logic [gscc_pkg::CFG_W-1:0]  i_cfg_data,
    input  gscc_pkg::t_in_item          i_in_item,
    input  gscc_pkg::t_cmd              i_cmd,
    output gscc_pkg::t_status           o_status,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output gscc_pkg::t_out_item         o_out_item
);
    import gscc_pkg::*;

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int CLR_N = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int CLR_W = $clog2(CLR_N);
    localparam logic signed [WIDE_W-1:0] MAXR = WIDE_W'(MAX_ROWS);
    localparam logic signed [WIDE_W-1:0] MAXC = WIDE_W'(MAX_COLS);
    localparam logic signed [WIDE_W-1:0] ONE  = WIDE_W'(1);

    function automatic logic signed [WIDE_W-1:0] clampd(
        input logic signed [WIDE_W-1:0] x,
        input logic signed [WIDE_W-1:0] n
    );
        logic signed [WIDE_W-1:0] y;
        if (x < 0) y = '0;
        else if (x >= n) y = n - ONE;
        else y = x;
        return y;
    endfunction

    // configuration
    logic [CFG_W-1:0] r_cfg_rows;
    logic [CFG_W-1:0] r_cfg_cols;
    logic signed [WIDE_W-1:0] cfg_rows_s;
    logic signed [WIDE_W-1:0] cfg_cols_s;
    logic signed [WIDE_W-1:0] eff_rows;
    logic signed [WIDE_W-1:0] eff_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rows <= CFG_RESET;
            r_cfg_cols <= CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GRID_ROWS: r_cfg_rows <= i_cfg_data;
                CFG_GRID_COLS: r_cfg_cols <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg_rows_s = $signed({{(WIDE_W-CFG_W){1'b0}}, r_cfg_rows});
    assign cfg_cols_s = $signed({{(WIDE_W-CFG_W){1'b0}}, r_cfg_cols});
    assign eff_rows = (cfg_rows_s == 0) ? ONE : ((cfg_rows_s > MAXR) ? MAXR : cfg_rows_s);
    assign eff_cols = (cfg_cols_s == 0) ? ONE : ((cfg_cols_s > MAXC) ? MAXC : cfg_cols_s);

    // captured item
    logic [1:0]               r_op;
    logic                     r_cell;
    logic signed [WIDE_W-1:0] r_ra, r_ca, r_rb, r_cb;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_in_item.operation;
            r_cell <= i_in_item.cell_blocked;
            r_ra   <= WIDE_W'(i_in_item.row_a);
            r_ca   <= WIDE_W'(i_in_item.col_a);
            // a point query is a segment with both ends at the point
            if (i_in_item.operation == OP_POINT) begin
                r_rb <= WIDE_W'(i_in_item.row_a);
                r_cb <= WIDE_W'(i_in_item.col_a);
            end else begin
                r_rb <= WIDE_W'(i_in_item.row_b);
                r_cb <= WIDE_W'(i_in_item.col_b);
            end
        end
    end

    logic in_a, in_b;
    assign in_a = (r_ra >= 0) && (r_ra < eff_rows) && (r_ca >= 0) && (r_ca < eff_cols);
    assign in_b = (r_rb >= 0) && (r_rb < eff_rows) && (r_cb >= 0) && (r_cb < eff_cols);

    // query setup
    logic signed [WIDE_W-1:0] dr, dc, adr, adc, dmaj, dmin, amaj, bmaj, bmin;
    logic signed [WIDE_W-1:0] s_d, s_e, lo_raw, hi_raw, eff_maj;
    logic                     s_colmaj;

    always_comb begin
        dr       = r_ra - r_rb;
        dc       = r_ca - r_cb;
        adr      = (dr < 0) ? -dr : dr;
        adc      = (dc < 0) ? -dc : dc;
        s_colmaj = (adr < adc);
        dmaj     = s_colmaj ? dc : dr;
        dmin     = s_colmaj ? dr : dc;
        amaj     = s_colmaj ? r_ca : r_ra;
        bmaj     = s_colmaj ? r_cb : r_rb;
        bmin     = s_colmaj ? r_rb : r_cb;
        eff_maj  = s_colmaj ? eff_cols : eff_rows;
        // divisor kept positive; the numerator's sign moves into the step
        s_d      = (dmaj == 0) ? ONE : ((dmaj < 0) ? -dmaj : dmaj);
        s_e      = (dmaj < 0) ? -dmin : dmin;
        lo_raw   = ((amaj < bmaj) ? amaj : bmaj) - ONE;
        hi_raw   = ((amaj > bmaj) ? amaj : bmaj) + ONE;
    end

    logic                     r_inb, r_colmaj;
    logic signed [WIDE_W-1:0] r_d, r_e, r_bmaj, r_bmin, r_lo, r_hi;

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_inb    <= in_a && in_b;
            r_colmaj <= s_colmaj;
            r_d      <= s_d;
            r_e      <= s_e;
            r_bmaj   <= bmaj;
            r_bmin   <= bmin;
            r_lo     <= clampd(lo_raw, eff_maj);
            r_hi     <= clampd(hi_raw, eff_maj);
        end
    end

    // walk: minor = floor quotient r_q, remainder r_rem in [0, r_d)
    logic signed [WIDE_W-1:0] r_m, r_q, r_rem;
    logic signed [WIDE_W-1:0] t_min, eff_min, nb_lo, nb_hi, delta, rs;
    logic                     t_in, at_end;

    always_comb begin
        t_min   = r_q + (((r_q < 0) && (r_rem != 0)) ? ONE : '0);
        eff_min = r_colmaj ? eff_rows : eff_cols;
        t_in    = (t_min >= 0) && (t_min < eff_min);
        nb_lo   = clampd(t_min - ONE, eff_min);
        nb_hi   = clampd(t_min + ONE, eff_min);
        delta   = i_cmd.dir_up ? r_e : -r_e;
        rs      = r_rem + delta;
        at_end  = i_cmd.dir_up ? (r_m == r_hi) : (r_m == r_lo);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_m   <= r_bmaj;
            r_q   <= r_bmin;
            r_rem <= '0;
        end else if (i_cmd.walk_step) begin
            r_m <= i_cmd.dir_up ? (r_m + ONE) : (r_m - ONE);
            if (rs >= r_d) begin
                r_rem <= rs - r_d;
                r_q   <= r_q + ONE;
            end else if (rs < 0) begin
                r_rem <= rs + r_d;
                r_q   <= r_q - ONE;
            end else begin
                r_rem <= rs;
            end
        end
    end

    // occupancy memories: one row per word and a transposed copy, one column per word
    logic [MAX_COLS-1:0] r_row_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] r_col_mem [MAX_COLS];
    logic [MAX_COLS-1:0] r_row_rd;
    logic [MAX_ROWS-1:0] r_col_rd;
    logic [CLR_W-1:0]    r_clr_cnt;
    logic                clr_row, clr_col, wr_cell;

    assign clr_row = ({1'b0, r_clr_cnt} < (CLR_W+1)'(MAX_ROWS));
    assign clr_col = ({1'b0, r_clr_cnt} < (CLR_W+1)'(MAX_COLS));
    assign wr_cell = i_cmd.load_en && in_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear_en) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_en) begin
            if (clr_row) r_row_mem[r_clr_cnt[ROW_W-1:0]] <= '0;
        end else if (wr_cell) begin
            r_row_mem[r_ra[ROW_W-1:0]][r_ca[COL_W-1:0]] <= r_cell;
        end
        if (i_cmd.issue && !r_colmaj) r_row_rd <= r_row_mem[r_m[ROW_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_en) begin
            if (clr_col) r_col_mem[r_clr_cnt[COL_W-1:0]] <= '0;
        end else if (wr_cell) begin
            r_col_mem[r_ca[COL_W-1:0]][r_ra[ROW_W-1:0]] <= r_cell;
        end
        if (i_cmd.issue && r_colmaj) r_col_rd <= r_col_mem[r_m[COL_W-1:0]];
    end

    // neighbor indexes travel with the read beat
    logic [COL_W-1:0] r_cnb0, r_cnbl, r_cnbh;
    logic [ROW_W-1:0] r_rnb0, r_rnbl, r_rnbh;
    logic             r_eval_vld;
    logic             r_blocked;
    logic             hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_cnb0 <= t_min[COL_W-1:0];
            r_cnbl <= nb_lo[COL_W-1:0];
            r_cnbh <= nb_hi[COL_W-1:0];
            r_rnb0 <= t_min[ROW_W-1:0];
            r_rnbl <= nb_lo[ROW_W-1:0];
            r_rnbh <= nb_hi[ROW_W-1:0];
        end
    end

    always_comb begin
        if (r_colmaj) begin
            hit = r_eval_vld && (r_col_rd[r_rnb0] || r_col_rd[r_rnbl] || r_col_rd[r_rnbh]);
        end else begin
            hit = r_eval_vld && (r_row_rd[r_cnb0] || r_row_rd[r_cnbl] || r_row_rd[r_cnbh]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eval_vld <= 1'b0;
            r_blocked  <= 1'b0;
        end else begin
            r_eval_vld <= i_cmd.issue && t_in;
            if (i_cmd.setup) begin
                r_blocked <= 1'b0;
            end else if (hit) begin
                r_blocked <= 1'b1;
            end
        end
    end

    // result register
    logic      r_out_vld;
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.path_clear <= r_inb && !r_blocked;
            r_out.in_bounds  <= r_inb;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    assign o_status.clear_last = (r_clr_cnt == CLR_W'(CLR_N - 1));
    assign o_status.op         = r_op;
    assign o_status.in_bounds  = r_inb;
    assign o_status.at_end     = at_end;
    assign o_status.out_busy   = r_out_vld && !i_out_ready;

endmodule

// ----- hw/rtl/grid_segment_clearance_check_top.sv -----
// Occupancy grid clearance checker.
// Input channel (i_in_valid/o_in_ready, i_in_item): one beat is a cell load,
// a point query or a segment query. Loads give no result; each query gives
// one beat on the output channel (o_out_valid/i_out_ready, o_out_item).
// Configuration channel (i_cfg_valid/o_cfg_ready) sets the grid rows (index 0)
// and columns (index 1); it is always ready. The user must write it only while
// idle; the block itself does not enforce this. One item is worked at a time.
// A query walks the clamped span (hi - lo) of the segment's major axis and
// reads one grid word per step from a row-major or column-major copy of the
// grid; out-of-bounds queries skip the walk. After reset the grid is swept
// clear, one row and one column word a cycle; no input is taken until then.
// The result sits in an output register; if the receiver stalls, the block
// holds the beat and the next query waits only at its end for the register.
module grid_segment_clearance_check_top #(
    parameter int MAX_ROWS = gscc_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gscc_pkg::DEF_MAX_COLS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_index,
    input  logic [gscc_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  gscc_pkg::t_in_item         i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output gscc_pkg::t_out_item        o_out_item
);
    import gscc_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    gscc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    gscc_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

`ifndef NO_ASSERTIONS
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear_en |-> !o_in_ready)
        else $error("input ready during grid clear");

    a_out_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || i_out_ready))
        else $error("result written over a pending beat");

    a_out_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_out_valid)
        else $error("result beat not presented");

    a_walk_after_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.issue |-> !o_in_ready && !cmd.clear_en)
        else $error("walk step outside a query");
`endif

endmodule
